// ----- src/npvl_pkg.sv -----
// npvl_pkg: payload structs and request codes for the nearest point value lookup
// no dependencies; imported by nearest_point_value_lookup

package npvl_pkg;

   // request codes carried in req_type
   localparam logic [1:0] REQ_LOAD_POINT = 2'd0;
   localparam logic [1:0] REQ_LOAD_VALUE = 2'd1;
   localparam logic [1:0] REQ_QUERY      = 2'd2;
   localparam logic [1:0] REQ_READ_VALUE = 2'd3;

   // response status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // one request transfer
   typedef struct packed {
      logic [1:0]         req_type;
      logic [5:0]         entry_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [31:0] entry_value;
   } req_payload_type;

   // one response transfer
   typedef struct packed {
      logic signed [31:0] result_value;
      logic [5:0]         found_index;
      logic               status;
   } rsp_payload_type;

endpackage

// ----- src/nearest_point_value_lookup.sv -----
// nearest_point_value_lookup: point/value table with a linear nearest-point search
// depends on npvl_pkg for payload structs and request codes

// Usage: a request is taken when start is high and busy is low. Loads (point or
// value) are written at that edge, give no response and leave busy low. A read by
// index answers in the next cycle; a nearest query scans n entries, where n
// is points_in_use capped at MAX_POINTS (one table entry per cycle through a
// five-stage distance pipeline fed by the point memory's single read port), then
// drains the pipeline and reads the nearest entry's value. points_in_use is written
// via the csr port only while idle; the user must ensure it, the block does not.
// A query with no points in use, or a read at or beyond the count, answers in the
// next cycle with error status. Each response is on rsp_payload for exactly one
// cycle with rsp_strobe high; the receiver cannot stall it, so it must take every
// response as it comes. busy stays high until the response cycle has ended.

module nearest_point_value_lookup #(
   parameter int MAX_POINTS = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  npvl_pkg::req_payload_type req_payload,
   output logic                     rsp_strobe,
   output npvl_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [6:0]               csr_wdata
);

   import npvl_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NW  = $clog2(MAX_POINTS + 1);
   localparam int SQW = 2 * DW;
   localparam int DSW = SQW + 2;

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [6:0]          count_ff;
   logic [NW-1:0]       n_used;
   logic                accept;
   logic                in_range;

   // table storage
   logic [3*DW-1:0]     point_mem_ff [MAX_POINTS];
   logic [DW-1:0]       value_mem_ff [MAX_POINTS];
   logic [3*DW-1:0]     pt_rd_ff;
   logic [DW-1:0]       val_rd_ff;
   logic [AW-1:0]       val_addr;

   // query and scan control
   logic [DW-1:0]       qx_ff, qy_ff, qz_ff;
   logic [NW-1:0]       addr_ff, addr_in;
   logic                issue;

   // distance pipeline
   logic                rd_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [NW-1:0]       rd_idx_ff, s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [DW:0]         dx_ff, dy_ff, dz_ff;
   logic [DW-1:0]       mx_ff, my_ff, mz_ff;
   logic [SQW-1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [DSW-1:0]      dist_ff;
   logic [DW-1:0]       px, py, pz;

   // best candidate so far
   logic                best_set_ff;
   logic [NW-1:0]       best_idx_ff;
   logic [DSW-1:0]      best_dist_ff;
   logic                take_best;

   // response registers
   logic                err_ff, err_in;
   logic [5:0]          idx_out_ff, idx_out_in;

   logic                pipe_busy;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // count in use, saturated to the table depth
   always_comb begin
      if (32'(count_ff) > MAX_POINTS) begin
         n_used = NW'(MAX_POINTS);
      end else begin
         n_used = NW'(count_ff);
      end
   end

   assign in_range = (32'(req_payload.entry_index) < MAX_POINTS);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_wdata;
      end
   end

   // point memory: write on load, one registered read per cycle for the scan
   always_ff @(posedge clock) begin
      if (accept && req_payload.req_type == REQ_LOAD_POINT && in_range) begin
         point_mem_ff[AW'(req_payload.entry_index)] <= {DW'(req_payload.coord_x),
                                                        DW'(req_payload.coord_y),
                                                        DW'(req_payload.coord_z)};
      end
      pt_rd_ff <= point_mem_ff[AW'(addr_ff)];
   end

   // value memory: request index while idle, best entry otherwise
   assign val_addr = (state_ff == ST_IDLE) ? AW'(req_payload.entry_index) : AW'(best_idx_ff);

   always_ff @(posedge clock) begin
      if (accept && req_payload.req_type == REQ_LOAD_VALUE && in_range) begin
         value_mem_ff[AW'(req_payload.entry_index)] <= DW'(req_payload.entry_value);
      end
      val_rd_ff <= value_mem_ff[val_addr];
   end

   // query point capture
   always_ff @(posedge clock) begin
      if (accept) begin
         qx_ff <= DW'(req_payload.coord_x);
         qy_ff <= DW'(req_payload.coord_y);
         qz_ff <= DW'(req_payload.coord_z);
      end
   end

   assign pipe_busy = rd_v_ff || s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff;
   assign issue     = (state_ff == ST_SCAN) && (addr_ff != n_used);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      err_in     = err_ff;
      idx_out_in = idx_out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
            if (accept) begin
               unique case (req_payload.req_type)
                  REQ_QUERY: begin
                     idx_out_in = '0;
                     if (n_used == '0) begin
                        err_in   = STATUS_ERROR;
                        state_in = ST_RESP;
                     end else begin
                        err_in   = STATUS_OK;
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_READ_VALUE: begin
                     idx_out_in = req_payload.entry_index;
                     err_in     = (32'(req_payload.entry_index) < 32'(n_used)) ?
                                  STATUS_OK : STATUS_ERROR;
                     state_in   = ST_RESP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // best index is final once the pipeline is empty
            if (!pipe_busy) begin
               idx_out_in = 6'(best_idx_ff);
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      idx_out_ff <= idx_out_in;
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= issue;
         s1_v_ff <= rd_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   assign {px, py, pz} = pt_rd_ff;

   // distance pipeline: difference, magnitude, square, sum
   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      s1_idx_ff <= rd_idx_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_idx_ff <= s3_idx_ff;

      dx_ff <= {qx_ff[DW-1], qx_ff} - {px[DW-1], px};
      dy_ff <= {qy_ff[DW-1], qy_ff} - {py[DW-1], py};
      dz_ff <= {qz_ff[DW-1], qz_ff} - {pz[DW-1], pz};

      mx_ff <= dx_ff[DW] ? DW'(~dx_ff + 1'b1) : DW'(dx_ff);
      my_ff <= dy_ff[DW] ? DW'(~dy_ff + 1'b1) : DW'(dy_ff);
      mz_ff <= dz_ff[DW] ? DW'(~dz_ff + 1'b1) : DW'(dz_ff);

      sqx_ff <= SQW'(mx_ff) * SQW'(mx_ff);
      sqy_ff <= SQW'(my_ff) * SQW'(my_ff);
      sqz_ff <= SQW'(mz_ff) * SQW'(mz_ff);

      dist_ff <= DSW'(sqx_ff) + DSW'(sqy_ff) + DSW'(sqz_ff);
   end

   // keep the first strictly nearest entry
   assign take_best = s4_v_ff && (!best_set_ff || (dist_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_set_ff <= 1'b0;
      end else if (accept) begin
         best_set_ff <= 1'b0;
      end else if (take_best) begin
         best_set_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         best_idx_ff <= '0;
      end else if (take_best) begin
         best_idx_ff  <= s4_idx_ff;
         best_dist_ff <= dist_ff;
      end
   end

   // response transfer
   assign rsp_strobe = (state_ff == ST_RESP);

   always_comb begin
      rsp_payload.result_value = (err_ff == STATUS_ERROR) ? 32'sd0 : 32'(signed'(val_rd_ff));
      rsp_payload.found_index  = idx_out_ff;
      rsp_payload.status       = err_ff;
   end

`ifndef NO_ASSERTIONS
   // the sequencer returns to idle right after a response
   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("block still busy after response");

   // error responses carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STATUS_ERROR) |-> (rsp_payload.result_value == 0))
      else $error("error response with non-zero value");

   // distance pipeline only runs during a query scan or its drain
   a_pipe_in_query: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance pipeline active outside a query");

   // loads leave the block idle
   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_payload.req_type == REQ_LOAD_POINT ||
                  req_payload.req_type == REQ_LOAD_VALUE)) |=> !busy)
      else $error("load made the block busy");

   // a successful query response points at an entry in use
   a_found_in_use: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.status == STATUS_OK) |-> (32'(idx_out_ff) < 32'(n_used)))
      else $error("response index beyond the count in use");
`endif

endmodule
